// ===== sv/usd_pkg.sv =====
// Shared types, constants and decode functions for the UTF-8 stream decoder.
`timescale 1ns / 1ps
`default_nettype none

package usd_pkg;

  localparam logic [7:0]  AsciiLimit  = 8'h80;
  localparam logic [7:0]  Lead2Mask   = 8'hE0;
  localparam logic [7:0]  Lead2Code   = 8'hC0;
  localparam logic [7:0]  Lead3Mask   = 8'hF0;
  localparam logic [7:0]  Lead3Code   = 8'hE0;
  localparam logic [7:0]  Lead4Mask   = 8'hF8;
  localparam logic [7:0]  Lead4Code   = 8'hF0;
  localparam logic [7:0]  ContMask    = 8'h3F;
  localparam logic [7:0]  Lead2Bits   = 8'h1F;
  localparam logic [7:0]  Lead3Bits   = 8'h0F;
  localparam logic [7:0]  Lead4Bits   = 8'h07;
  localparam logic [20:0] Replacement = 21'h00FFFD;

  localparam logic [2:0] LenInvalid = 3'd0;
  localparam logic [2:0] LenAscii   = 3'd1;
  localparam logic [2:0] LenTwo     = 3'd2;
  localparam logic [2:0] LenThree   = 3'd3;
  localparam logic [2:0] LenFour    = 3'd4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } in_t;

  typedef struct packed {
    logic [20:0] code_point;
    logic [2:0]  byte_count;
    logic        run_last;
  } out_t;

  // Bytes to scan, oldest in entry 0, and how many of them are live (1 to 4).
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      count;
  } job_t;

  function automatic logic [2:0] seq_len(input logic [7:0] b);
    logic [2:0] len;
    if (b < AsciiLimit) begin
      len = LenAscii;
    end else if ((b & Lead2Mask) == Lead2Code) begin
      len = LenTwo;
    end else if ((b & Lead3Mask) == Lead3Code) begin
      len = LenThree;
    end else if ((b & Lead4Mask) == Lead4Code) begin
      len = LenFour;
    end else begin
      len = LenInvalid;
    end
    return len;
  endfunction

  function automatic logic [20:0] combine(input logic [3:0][7:0] p, input logic [2:0] n);
    logic [7:0]  b0;
    logic [7:0]  b1;
    logic [7:0]  b2;
    logic [7:0]  b3;
    logic [20:0] cp;
    b0 = p[0];
    b1 = p[1] & ContMask;
    b2 = p[2] & ContMask;
    b3 = p[3] & ContMask;
    case (n)
      LenTwo: begin
        cp = {10'd0, b0[4:0] & Lead2Bits[4:0], b1[5:0]};
      end
      LenThree: begin
        cp = {5'd0, b0[3:0] & Lead3Bits[3:0], b1[5:0], b2[5:0]};
      end
      default: begin
        cp = {b0[2:0] & Lead4Bits[2:0], b1[5:0], b2[5:0], b3[5:0]};
      end
    endcase
    return cp;
  endfunction

endpackage

`default_nettype wire

// ===== sv/usd_front.sv =====
// Front end: accepts bytes, tracks the open sequence and emits scan jobs.
`timescale 1ns / 1ps
`default_nettype none

module usd_front
  import usd_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic accept_i,
  input  wire in_t  in_data_i,
  output logic      job_push_o,
  output job_t      job_o
);

  logic [1:0]      held_count_q, held_count_d;
  logic [2:0]      expected_length_q, expected_length_d;
  logic [7:0]      held_bytes_q [3];
  logic            hold_byte;
  logic [3:0][7:0] window;
  logic [2:0]      total;
  logic [2:0]      lead_len;
  logic [7:0]      b;

  assign b = in_data_i.data_byte;

  // Gather held bytes with the new byte appended behind them.
  always_comb begin
    window = '0;
    case (held_count_q)
      2'd0: begin
        window[0] = b;
      end
      2'd1: begin
        window[0] = held_bytes_q[0];
        window[1] = b;
      end
      2'd2: begin
        window[0] = held_bytes_q[0];
        window[1] = held_bytes_q[1];
        window[2] = b;
      end
      default: begin
        window[0] = held_bytes_q[0];
        window[1] = held_bytes_q[1];
        window[2] = held_bytes_q[2];
        window[3] = b;
      end
    endcase
  end

  assign total    = {1'b0, held_count_q} + 3'd1;
  assign lead_len = seq_len(b);

  always_comb begin
    held_count_d      = held_count_q;
    expected_length_d = expected_length_q;
    hold_byte         = 1'b0;
    job_push_o        = 1'b0;
    if (accept_i) begin
      if (in_data_i.final_byte) begin
        job_push_o        = 1'b1;
        held_count_d      = 2'd0;
        expected_length_d = 3'd0;
      end else if (held_count_q == 2'd0) begin
        if (lead_len == LenAscii || lead_len == LenInvalid) begin
          job_push_o = 1'b1;
        end else begin
          hold_byte         = 1'b1;
          held_count_d      = 2'd1;
          expected_length_d = lead_len;
        end
      end else if (total >= expected_length_q) begin
        job_push_o        = 1'b1;
        held_count_d      = 2'd0;
        expected_length_d = 3'd0;
      end else begin
        hold_byte    = 1'b1;
        held_count_d = total[1:0];
      end
    end
  end

  assign job_o.bytes = window;
  assign job_o.count = total;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_count_q      <= 2'd0;
      expected_length_q <= 3'd0;
    end else begin
      held_count_q      <= held_count_d;
      expected_length_q <= expected_length_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (hold_byte) begin
      case (held_count_q)
        2'd0:    held_bytes_q[0] <= b;
        2'd1:    held_bytes_q[1] <= b;
        default: held_bytes_q[2] <= b;
      endcase
    end
  end

  a_hold_shorter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_count_q != 2'd0 |-> {1'b0, held_count_q} < expected_length_q)
    else $error("held bytes reach expected length");

endmodule

`default_nettype wire

// ===== sv/usd_job_fifo.sv =====
// Two-entry job queue between the front end and the scanner.
`timescale 1ns / 1ps
`default_nettype none

module usd_job_fifo
  import usd_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire job_t push_data_i,
  output logic      full_o,
  input  wire logic pop_i,
  output logic      empty_o,
  output job_t      pop_data_o
);

  job_t       slot_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  assign full_o     = (count_q == 2'd2);
  assign empty_o    = (count_q == 2'd0);
  assign pop_data_o = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3)
    else $error("job queue count out of range");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> count_q != 2'd0)
    else $error("job queue popped while empty");

endmodule

`default_nettype wire

// ===== sv/usd_back.sv =====
// Back end: scans one job per pass and emits one code point per cycle while the output register is free.
`timescale 1ns / 1ps
`default_nettype none

module usd_back
  import usd_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic job_empty_i,
  input  wire job_t job_i,
  output logic      job_pop_o,
  output logic      empty_o,
  input  wire logic pop_i,
  output out_t      out_data_o
);

  logic            w_valid_q, w_valid_d;
  logic [3:0][7:0] w_bytes_q, w_bytes_d;
  logic [2:0]      w_rem_q, w_rem_d;
  logic            out_valid_q, out_valid_d;
  out_t            out_q, out_d;
  logic            out_free;
  logic            step;
  logic            step_last;
  logic [2:0]      len;
  logic [2:0]      cnt;
  logic [20:0]     cp;
  logic [3:0][7:0] shifted;

  assign out_free = !out_valid_q || pop_i;
  assign step     = w_valid_q && out_free;
  assign len      = seq_len(w_bytes_q[0]);

  // Decode at the head of the remaining bytes.
  always_comb begin
    if (len == LenAscii) begin
      cp  = {13'd0, w_bytes_q[0]};
      cnt = LenAscii;
    end else if (len != LenInvalid && len <= w_rem_q) begin
      cp  = combine(w_bytes_q, len);
      cnt = len;
    end else begin
      cp  = Replacement;
      cnt = LenAscii;
    end
  end

  assign step_last = (cnt == w_rem_q);
  assign shifted   = w_bytes_q >> {cnt, 3'b000};
  assign job_pop_o = !job_empty_i && (!w_valid_q || (step && step_last));

  always_comb begin
    w_valid_d   = w_valid_q;
    w_bytes_d   = w_bytes_q;
    w_rem_d     = w_rem_q;
    out_valid_d = out_valid_q && !pop_i;
    out_d       = out_q;
    if (step) begin
      out_valid_d      = 1'b1;
      out_d.code_point = cp;
      out_d.byte_count = cnt;
      out_d.run_last   = step_last;
      w_bytes_d        = shifted;
      w_rem_d          = w_rem_q - cnt;
      if (step_last) begin
        w_valid_d = 1'b0;
      end
    end
    // Load the next job as soon as the current one drains.
    if (job_pop_o) begin
      w_valid_d = 1'b1;
      w_bytes_d = job_i.bytes;
      w_rem_d   = job_i.count;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      w_valid_q   <= w_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    w_bytes_q <= w_bytes_d;
    w_rem_q   <= w_rem_d;
    out_q     <= out_d;
  end

  assign empty_o    = !out_valid_q;
  assign out_data_o = out_q;

  a_rem_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    w_valid_q |-> (w_rem_q != 3'd0 && w_rem_q <= LenFour))
    else $error("scan job holds no bytes");

  a_step_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |-> cnt <= w_rem_q)
    else $error("code point consumes more bytes than remain");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.byte_count != 3'd0 && out_q.byte_count <= LenFour))
    else $error("result byte count out of range");

endmodule

`default_nettype wire

// ===== sv/utf8_stream_decoder_top.sv =====
// Top level of the UTF-8 stream decoder.
//
// Input channel: one text byte per transaction with a flag on the final byte
// of each string; a transaction completes when push_i is high and full_o low.
// Result channel: one code point per transaction with its byte count and a
// flag on the last result caused by an input byte; the oldest result is on
// out_data_o while empty_o is low and is taken when pop_i is high.
// An input byte produces zero to three results. A byte that produces results
// shows its first one after passing the job queue slot, the scanner window
// register and the output register.
// Throughput is one byte per cycle while each byte gives at most one result and the receiver takes results;
// the scanner emits one result per cycle, so a byte that ends a string inside
// a sequence holds the scanner until it has emitted every result it produces.
// Reset clears the open sequence, the job queue, the scanner and the output register's valid flag.
// When the receiver stalls, the output register holds its result, the
// scanner and the two-entry job queue fill, and full_o then stalls the sender.
`timescale 1ns / 1ps
`default_nettype none

module utf8_stream_decoder_top
  import usd_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  output logic      full_o,
  input  wire in_t  in_data_i,
  output logic      empty_o,
  input  wire logic pop_i,
  output out_t      out_data_o
);

  logic accept;
  logic job_push;
  job_t job_in;
  logic job_pop;
  logic job_empty;
  job_t job_out;

  assign accept = push_i && !full_o;

  usd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .in_data_i  (in_data_i),
    .job_push_o (job_push),
    .job_o      (job_in)
  );

  usd_job_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (job_push),
    .push_data_i (job_in),
    .full_o      (full_o),
    .pop_i       (job_pop),
    .empty_o     (job_empty),
    .pop_data_o  (job_out)
  );

  usd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_empty_i (job_empty),
    .job_i       (job_out),
    .job_pop_o   (job_pop),
    .empty_o     (empty_o),
    .pop_i       (pop_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire
